// ----- sv/cpi_pkg.sv -----
package cpi_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_CIRCLES_DEF = 16;
  localparam int COORD_WIDTH_DEF = 16;

  // Result fields have fixed widths, whatever the capacity.
  localparam int RESULT_CAP = 16;
  localparam int INDEX_W    = 4;
  localparam int MASK_W     = 16;
  localparam int COUNT_W    = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW_RD,
    ST_SWEEP,
    ST_DRAIN,
    ST_EMIT
  } cpi_state_t;

endpackage

// ----- sv/circle_pairwise_intersection.sv -----
// Loading: one circle per cycle; in_ready is high whenever no pass is running.
// Pass: each result row takes a row read, one read per stored circle, the pair test
// pipeline and an emit step; a set of N stored circles gives min(N,16) result rows.
// A stalled result holds the pass until its transfer. Reset (rst_n low, synchronous)
// clears the fill count, drop flag and control state; the circle memory is not cleared.
module circle_pairwise_intersection #(
  parameter int MAX_CIRCLES = cpi_pkg::MAX_CIRCLES_DEF,
  parameter int COORD_WIDTH = cpi_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic        [COORD_WIDTH-1:0] in_radius,
  input  logic                          in_last_circle,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cpi_pkg::INDEX_W-1:0]   out_circle_index,
  output logic [cpi_pkg::MASK_W-1:0]    out_touch_mask,
  output logic [cpi_pkg::COUNT_W-1:0]   out_touch_count,
  output logic                          out_last_result,
  output logic                          out_overflowed
);
  import cpi_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = $clog2(MAX_CIRCLES);
  localparam int CNT_W = $clog2(MAX_CIRCLES + 1);
  localparam int EW    = 3 * CW;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  cpi_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] loaded_r;
  logic             drop_r;
  logic [AW-1:0]    row_i_r;
  logic [AW-1:0]    sweep_j_r;
  logic             cap_r;

  logic in_xfer;
  logic out_free;
  logic sweep_last;
  logic row_last;
  logic store_ok;

  assign in_ready   = (state_r == ST_LOAD);
  assign in_xfer    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign store_ok   = (loaded_r < CNT_W'(MAX_CIRCLES));
  assign sweep_last = (CNT_W'(sweep_j_r) + CNT_W'(1) == loaded_r);
  // The pass stops at the last stored circle or at the result cap, whichever comes first.
  assign row_last   = (CNT_W'(row_i_r) + CNT_W'(1) == loaded_r) ||
                      (int'(row_i_r) + 1 == RESULT_CAP);

  // ---------------------------------------------------------------------------
  // Circle memory: one entry per circle, {x, y, radius}, one write and one read port.
  // ---------------------------------------------------------------------------
  logic [EW-1:0] circ_mem [MAX_CIRCLES];
  logic [EW-1:0] mem_q_r;
  logic [AW-1:0] rd_addr;

  assign rd_addr = (state_r == ST_ROW_RD) ? row_i_r : sweep_j_r;

  always_ff @(posedge clk) begin
    if (in_xfer && store_ok) begin
      circ_mem[loaded_r[AW-1:0]] <= {in_center_x, in_center_y, in_radius};
    end
    mem_q_r <= circ_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  logic s3_v_r, s3_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_last_circle) begin
          state_nxt = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s3_v_r && s3_last_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = row_last ? ST_LOAD : ST_ROW_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Fill count, drop flag, row and sweep counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= '0;
      drop_r    <= 1'b0;
      row_i_r   <= '0;
      sweep_j_r <= '0;
      cap_r     <= 1'b0;
    end else begin
      cap_r <= (state_r == ST_ROW_RD);
      if (in_xfer) begin
        if (store_ok) begin
          loaded_r <= loaded_r + CNT_W'(1);
        end else begin
          drop_r <= 1'b1;
        end
        row_i_r <= '0;
      end
      if (state_r == ST_ROW_RD) begin
        sweep_j_r <= '0;
      end else if (state_r == ST_SWEEP && !sweep_last) begin
        sweep_j_r <= sweep_j_r + AW'(1);
      end
      if (state_r == ST_EMIT && out_free) begin
        if (row_last) begin
          loaded_r <= '0;
          drop_r   <= 1'b0;
        end else begin
          row_i_r <= row_i_r + AW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Row circle: captured from the memory the cycle after its read.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] ci_x_r, ci_y_r;
  logic        [CW-1:0] ci_r_r;

  always_ff @(posedge clk) begin
    if (cap_r) begin
      ci_x_r <= mem_q_r[EW-1:2*CW];
      ci_y_r <= mem_q_r[2*CW-1:CW];
      ci_r_r <= mem_q_r[CW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Pair test pipeline. Tags travel with the data: valid, column index, last column.
  // ---------------------------------------------------------------------------
  logic          rd_v_r, rd_last_r;
  logic [AW-1:0] rd_j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= (state_r == ST_SWEEP);
    end
    rd_j_r    <= sweep_j_r;
    rd_last_r <= sweep_last;
  end

  // Stage 1: absolute differences and the radius sum.
  logic signed [CW-1:0] cj_x, cj_y;
  logic        [CW-1:0] cj_r;
  logic        [CW:0]   dxs, dys;
  logic        [CW-1:0] dx_abs, dy_abs, rd_abs;
  logic        [CW:0]   rs_sum;

  assign cj_x = mem_q_r[EW-1:2*CW];
  assign cj_y = mem_q_r[2*CW-1:CW];
  assign cj_r = mem_q_r[CW-1:0];

  always_comb begin
    dxs    = {ci_x_r[CW-1], ci_x_r} - {cj_x[CW-1], cj_x};
    dys    = {ci_y_r[CW-1], ci_y_r} - {cj_y[CW-1], cj_y};
    dx_abs = dxs[CW] ? CW'(-dxs) : dxs[CW-1:0];
    dy_abs = dys[CW] ? CW'(-dys) : dys[CW-1:0];
    rd_abs = (ci_r_r >= cj_r) ? (ci_r_r - cj_r) : (cj_r - ci_r_r);
    rs_sum = {1'b0, ci_r_r} + {1'b0, cj_r};
  end

  logic          s1_v_r, s1_last_r, s1_self_r;
  logic [AW-1:0] s1_j_r;
  logic [CW-1:0] s1_dx_r, s1_dy_r, s1_rd_r;
  logic [CW:0]   s1_rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= rd_v_r;
    end
    s1_j_r    <= rd_j_r;
    s1_last_r <= rd_last_r;
    s1_self_r <= (rd_j_r == row_i_r);
    s1_dx_r   <= dx_abs;
    s1_dy_r   <= dy_abs;
    s1_rd_r   <= rd_abs;
    s1_rs_r   <= rs_sum;
  end

  // Stage 2: the four squares.
  logic            s2_v_r, s2_last_r, s2_self_r;
  logic [AW-1:0]   s2_j_r;
  logic [2*CW-1:0] s2_dx2_r, s2_dy2_r, s2_lo2_r;
  logic [2*CW+1:0] s2_hi2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_j_r    <= s1_j_r;
    s2_last_r <= s1_last_r;
    s2_self_r <= s1_self_r;
    s2_dx2_r  <= s1_dx_r * s1_dx_r;
    s2_dy2_r  <= s1_dy_r * s1_dy_r;
    s2_lo2_r  <= s1_rd_r * s1_rd_r;
    s2_hi2_r  <= s1_rs_r * s1_rs_r;
  end

  // Stage 3: distance squared and the two bounds; a circle never touches itself.
  logic [2*CW:0]   d2;
  logic [2*CW+1:0] d2_ext, lo2_ext;
  logic            touch;

  always_comb begin
    d2      = {1'b0, s2_dx2_r} + {1'b0, s2_dy2_r};
    d2_ext  = {1'b0, d2};
    lo2_ext = {2'b00, s2_lo2_r};
    touch   = (lo2_ext <= d2_ext) && (d2_ext <= s2_hi2_r) && !s2_self_r;
  end

  logic          s3_touch_r;
  logic [AW-1:0] s3_j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_j_r     <= s2_j_r;
    s3_last_r  <= s2_last_r;
    s3_touch_r <= touch;
  end

  // ---------------------------------------------------------------------------
  // Row accumulator: mask over the first sixteen columns, count saturating at fifteen.
  // ---------------------------------------------------------------------------
  logic [MASK_W-1:0]  acc_mask_r;
  logic [COUNT_W-1:0] acc_cnt_r;
  logic [INDEX_W-1:0] s3_j_lo;

  assign s3_j_lo = INDEX_W'(s3_j_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_ROW_RD) begin
      acc_mask_r <= '0;
      acc_cnt_r  <= '0;
    end else if (s3_v_r && s3_touch_r) begin
      if (int'(s3_j_r) < RESULT_CAP) begin
        acc_mask_r[s3_j_lo] <= 1'b1;
      end
      if (acc_cnt_r != COUNT_MAX) begin
        acc_cnt_r <= acc_cnt_r + COUNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: a finished row waits here until its transfer.
  // ---------------------------------------------------------------------------
  logic               out_valid_r;
  logic [INDEX_W-1:0] out_index_r;
  logic [MASK_W-1:0]  out_mask_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic               out_last_r, out_ovf_r;
  logic               out_load;

  assign out_load = (state_r == ST_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= INDEX_W'(row_i_r);
      out_mask_r  <= acc_mask_r;
      out_cnt_r   <= acc_cnt_r;
      out_last_r  <= row_last;
      out_ovf_r   <= drop_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_circle_index = out_index_r;
  assign out_touch_mask   = out_mask_r;
  assign out_touch_count  = out_cnt_r;
  assign out_last_result  = out_last_r;
  assign out_overflowed   = out_ovf_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(MAX_CIRCLES) >= loaded_r)
    else $error("fill count beyond capacity");

  a_pipe_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (state_r == ST_SWEEP || state_r == ST_DRAIN))
    else $error("pair pipeline active outside a pass");

  a_row_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> (CNT_W'(row_i_r) < loaded_r && int'(row_i_r) < RESULT_CAP))
    else $error("row index outside the stored set");

  a_no_self: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !acc_mask_r[INDEX_W'(row_i_r)])
    else $error("circle marked as touching itself");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && (out_index_r == INDEX_W'($past(row_i_r))))
    else $error("emitted row not presented");

endmodule

// ----- test/tb_circle_pairwise_intersection.sv -----
module tb_circle_pairwise_intersection;
  import cpi_pkg::*;

  localparam int NCIRC   = MAX_CIRCLES_DEF;
  localparam int COORD_W = COORD_WIDTH_DEF;

  // One circle waiting to be offered on the input channel. A set of circles ends
  // with the item that has last set. When wait_idle is set, the sender holds this
  // item back until every result of earlier sets has come out.
  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic        [COORD_W-1:0] rad;
    logic                      last;
    bit                        wait_idle;
  } circle_item_t;

  // One per-circle intersection report, as the block should emit it.
  typedef struct {
    logic [INDEX_W-1:0] idx;
    logic [MASK_W-1:0]  mask;
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               ovf;
  } touch_report_t;

  // These are the ways a random circle is placed relative to the previous circle of
  // its set, so that exact tangency, near misses and coincidence show up often.
  typedef enum {
    SHAPE_WIDE,
    SHAPE_CLUSTER,
    SHAPE_TANGENT,
    SHAPE_NEAR_MISS,
    SHAPE_NESTED,
    SHAPE_COPY
  } circle_shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_center_x = '0;
  logic signed [COORD_W-1:0] in_center_y = '0;
  logic        [COORD_W-1:0] in_radius = '0;
  logic                      in_last_circle = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [INDEX_W-1:0] out_circle_index;
  logic [MASK_W-1:0]  out_touch_mask;
  logic [COUNT_W-1:0] out_touch_count;
  logic               out_last_result;
  logic               out_overflowed;

  circle_pairwise_intersection u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius        (in_radius),
    .in_last_circle   (in_last_circle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_circle_index (out_circle_index),
    .out_touch_mask   (out_touch_mask),
    .out_touch_count  (out_touch_count),
    .out_last_result  (out_last_result),
    .out_overflowed   (out_overflowed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  circle_item_t  circle_q[$];
  touch_report_t report_q[$];
  int            items_queued = 0;
  int            mismatches = 0;
  int            reports_seen = 0;
  bit            reports_idle = 1'b1;

  // Shadow copy of the circle set that the block is currently collecting.
  logic signed [COORD_W-1:0] set_x [NCIRC];
  logic signed [COORD_W-1:0] set_y [NCIRC];
  logic        [COORD_W-1:0] set_r [NCIRC];
  int                        set_count = 0;
  bit                        set_dropped = 1'b0;

  // Two circles touch when (ra-rb)^2 <= d^2 <= (ra+rb)^2. All terms stay well
  // below 2^63, so plain 64-bit integer arithmetic is exact here.
  function automatic bit circles_touch(int a, int b);
    longint dx, dy, rsum, rdiff, dist2;
    dx    = longint'(set_x[a]) - longint'(set_x[b]);
    dy    = longint'(set_y[a]) - longint'(set_y[b]);
    rsum  = longint'(set_r[a]) + longint'(set_r[b]);
    rdiff = longint'(set_r[a]) - longint'(set_r[b]);
    dist2 = dx * dx + dy * dy;
    return (rdiff * rdiff <= dist2) && (dist2 <= rsum * rsum);
  endfunction

  // Stores one transferred circle. On the last circle of a set it works out one
  // report per stored circle and then clears the set.
  task automatic collect_circle(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
                                logic [COORD_W-1:0] rad, logic last);
    int            emit;
    touch_report_t rep;
    if (set_count < NCIRC) begin
      set_x[set_count] = cx;
      set_y[set_count] = cy;
      set_r[set_count] = rad;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      emit = (set_count < RESULT_CAP) ? set_count : RESULT_CAP;
      for (int i = 0; i < emit; i++) begin
        rep.idx   = INDEX_W'(i);
        rep.mask  = '0;
        rep.count = '0;
        for (int j = 0; j < set_count; j++) begin
          if (j != i && circles_touch(i, j)) begin
            if (j < MASK_W) rep.mask[j] = 1'b1;
            if (rep.count != COUNT_MAX) rep.count++;
          end
        end
        rep.last = (i == emit - 1);
        rep.ovf  = set_dropped;
        report_q.push_back(rep);
      end
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic queue_circle(longint cx, longint cy, longint rad, bit last, bit wait_idle);
    circle_item_t it;
    it.cx        = COORD_W'(cx);
    it.cy        = COORD_W'(cy);
    it.rad       = COORD_W'(rad);
    it.last      = last;
    it.wait_idle = wait_idle;
    circle_q.push_back(it);
    items_queued++;
  endtask

  // Queues one complete set of random circles. Tangent, near-miss, nested and copied
  // circles are placed relative to the previous one whenever the result fits the range.
  task automatic queue_random_set(int size, bit wait_idle);
    longint        px, py, pr, nx, ny, nr;
    circle_shape_t shape;
    int            pick;
    px = 0;
    py = 0;
    pr = 0;
    for (int k = 0; k < size; k++) begin
      pick = $urandom_range(0, 11);
      case (pick)
        0, 1:    shape = SHAPE_WIDE;
        2, 3, 4: shape = SHAPE_CLUSTER;
        5, 6:    shape = SHAPE_TANGENT;
        7, 8:    shape = SHAPE_NEAR_MISS;
        9, 10:   shape = SHAPE_NESTED;
        default: shape = SHAPE_COPY;
      endcase
      if (k == 0 && shape != SHAPE_WIDE) shape = SHAPE_CLUSTER;
      // The clustered placement is the fallback whenever a relative one does not fit.
      nx = longint'($urandom_range(0, 4095)) - 2048;
      ny = longint'($urandom_range(0, 4095)) - 2048;
      nr = longint'($urandom_range(0, 1536));
      case (shape)
        SHAPE_WIDE: begin
          nx = longint'($urandom_range(0, 65535)) - 32768;
          ny = longint'($urandom_range(0, 65535)) - 32768;
          nr = longint'($urandom_range(0, 65535));
        end
        SHAPE_TANGENT, SHAPE_NEAR_MISS: begin
          nr = longint'($urandom_range(0, 1024));
          if (px + pr + nr + 1 <= 32767) begin
            nx = px + pr + nr + ((shape == SHAPE_NEAR_MISS) ? 1 : 0);
            ny = py;
          end
        end
        SHAPE_NESTED: begin
          nr = pr / 2;
          if (px - (pr - nr) >= -32768) begin
            nx = px - (pr - nr);
            ny = py;
          end
        end
        SHAPE_COPY: begin
          nx = px;
          ny = py;
          nr = pr;
        end
        default: ;
      endcase
      queue_circle(nx, ny, nr, k == size - 1, wait_idle && k == 0);
      px = nx;
      py = ny;
      pr = nr;
    end
  endtask

  // Sender. The head of circle_q is the item on the pins while in_valid is high, and
  // it is dropped from the queue at the edge where its transfer happens. Bursts of
  // random length are separated by random gaps, except during the long receiver
  // hold-off, when the sender keeps offering so that the block backs up.
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit offer;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      offer = 1'b0;
      if (in_valid && in_ready) begin
        collect_circle(in_center_x, in_center_y, in_radius, in_last_circle);
        void'(circle_q.pop_front());
      end else if (in_valid) begin
        offer = 1'b1;
      end
      if (!offer) begin
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
        end else if (circle_q.size() > 0 &&
                     (!circle_q[0].wait_idle || (reports_idle && !in_valid))) begin
          // A held-back item also skips the edge of a transfer, since reports_idle
          // does not yet reflect the reports that transfer has just caused.
          offer = 1'b1;
          if (burst_left == 0) begin
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= offer;
      if (offer) begin
        in_center_x    <= circle_q[0].cx;
        in_center_y    <= circle_q[0].cy;
        in_radius      <= circle_q[0].rad;
        in_last_circle <= circle_q[0].last;
      end
    end
  end

  // Sampled away from the active edge, so the sender sees a settled value.
  always @(negedge clk) begin
    reports_idle <= (report_q.size() == 0);
  end

  // The long hold-off starts once, in the middle of a comparison pass, once at least
  // fourteen results have come out.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && reports_seen >= 14 && !reports_idle) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver. It switches between always ready, coin-flip ready and mostly stalled
  // in stretches of random length.
  int rdy_mode = 0;
  int rdy_left = 0;
  bit rdy_bit;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rdy_left  = 0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 2);
        rdy_left = $urandom_range(4, 50);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        0:       rdy_bit = 1'b1;
        1:       rdy_bit = ($urandom_range(0, 1) == 1);
        default: rdy_bit = ($urandom_range(0, 3) == 0);
      endcase
      out_ready <= rdy_bit && (hold_left == 0);
    end
  end

  // Checker. Every result transfer is matched against the oldest pending report.
  touch_report_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      reports_seen <= reports_seen + 1;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: index %0d mask %h count %0d last %b ovf %b",
                   out_circle_index, out_touch_mask, out_touch_count, out_last_result,
                   out_overflowed);
      end else begin
        want = report_q.pop_front();
        if (out_circle_index !== want.idx || out_touch_mask !== want.mask ||
            out_touch_count !== want.count || out_last_result !== want.last ||
            out_overflowed !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected index %0d mask %h count %0d last %b ovf %b,",
                     want.idx, want.mask, want.count, want.last, want.ovf,
                     " got index %0d mask %h count %0d last %b ovf %b",
                     out_circle_index, out_touch_mask, out_touch_count, out_last_result,
                     out_overflowed);
        end
      end
    end
  end

  initial begin
    int set_num;
    int size;

    // A lone circle: one report with an empty mask.
    queue_circle(16'sh1234, -16'sh0100, 16'h0080, 1'b1, 1'b0);

    // Coincident identical circles, external and internal tangency, a nested circle
    // that stays clear, two point circles on one centre and one point just beside it.
    queue_circle(0, 0, 16'h0500, 1'b0, 1'b0);
    queue_circle(0, 0, 16'h0500, 1'b0, 1'b0);
    queue_circle(16'h0A00, 0, 16'h0500, 1'b0, 1'b0);
    queue_circle(16'h0100, 0, 16'h0400, 1'b0, 1'b0);
    queue_circle(0, 0, 16'h0200, 1'b0, 1'b0);
    queue_circle(16'h3000, 16'h3000, 0, 1'b0, 1'b0);
    queue_circle(16'h3000, 16'h3000, 0, 1'b0, 1'b0);
    queue_circle(16'h3001, 16'h3000, 0, 1'b1, 1'b0);

    // Corners of the coordinate range with the largest and smallest radii.
    queue_circle(-32768, -32768, 16'hFFFF, 1'b0, 1'b0);
    queue_circle(32767, 32767, 16'hFFFF, 1'b0, 1'b0);
    queue_circle(32767, -32768, 0, 1'b0, 1'b0);
    queue_circle(-32768, 32767, 0, 1'b1, 1'b0);

    // Random sets. The first waits until the directed reports are all out. At least two
    // sets overrun the store, and in each the dropped circles include the last one.
    set_num = 0;
    while (items_queued < 110) begin
      if (set_num == 0) size = 17;
      else if (set_num == 3) size = 19;
      else if ($urandom_range(0, 9) == 0) size = $urandom_range(14, 19);
      else size = $urandom_range(1, 6);
      queue_random_set(size, set_num == 0 || (set_num != 1 && $urandom_range(0, 4) == 0));
      set_num++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (circle_q.size() != 0 || report_q.size() != 0 || in_valid) @(negedge clk);
    // Give a stray extra result time to show up.
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
sv/cpi_pkg.sv
sv/circle_pairwise_intersection.sv
test/tb_circle_pairwise_intersection.sv
